@@ rtl/core/pac_pkg.sv @@
// Shared types, constants and the Q16 reciprocal table for the pixel alpha converter.
package pac_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned PROD_W      = CHAN_W + RECIP_W;
  localparam int unsigned TBL_DEPTH   = 1 << CHAN_W;
  localparam logic [RECIP_W-1:0] RECIP_NUM  = 24'd16711680;  // 255 * 65536
  localparam logic [PROD_W:0]    ROUND_Q16  = 33'h0_0000_8000;
  localparam logic [15:0]        ROUND_PREM = 16'd127;
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'd255;

  typedef enum logic [1:0] {
    MODE_PREMUL   = 2'd0,
    MODE_UNPREMUL = 2'd1,
    MODE_SWAP     = 2'd2
  } conv_mode_t;

  // One pixel held in the input register, with its reciprocal already looked up.
  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic               frame_end;
    logic [RECIP_W-1:0] recip;
  } pix_stage_t;

  typedef logic [RECIP_W-1:0] recip_tbl_t [TBL_DEPTH];

  // round(255*65536/a) by shift-subtract; only used to build the constant table.
  function automatic logic [RECIP_W-1:0] recip_calc(input logic [CHAN_W-1:0] a);
    logic [RECIP_W-1:0] num;
    logic [RECIP_W-1:0] quo;
    logic [CHAN_W:0]    rem;
    quo = '0;
    rem = '0;
    num = RECIP_NUM + RECIP_W'(a >> 1);
    if (a != '0) begin
      for (int i = RECIP_W - 1; i >= 0; i--) begin
        rem = {rem[CHAN_W-1:0], num[i]};
        if (rem >= {1'b0, a}) begin
          rem    = rem - {1'b0, a};
          quo[i] = 1'b1;
        end
      end
    end
    return quo;
  endfunction

  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t tbl;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl[i] = recip_calc(CHAN_W'(i));
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

endpackage

@@ rtl/core/pac_in_reg.sv @@
// Input register: captures one pixel beat and its reciprocal from the table.
module pac_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic                       drain,
  input  logic [pac_pkg::CHAN_W-1:0] red,
  input  logic [pac_pkg::CHAN_W-1:0] green,
  input  logic [pac_pkg::CHAN_W-1:0] blue,
  input  logic [pac_pkg::CHAN_W-1:0] alpha,
  input  logic                       frame_end,
  output logic                       valid,
  output pac_pkg::pix_stage_t        pix
);
  import pac_pkg::*;

  logic       valid_r, valid_nxt;
  pix_stage_t pix_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r.red       <= red;
      pix_r.green     <= green;
      pix_r.blue      <= blue;
      pix_r.alpha     <= alpha;
      pix_r.frame_end <= frame_end;
      pix_r.recip     <= RECIP_TBL[alpha];
    end
  end

  assign valid = valid_r;
  assign pix   = pix_r;

endmodule

@@ rtl/core/pac_lane.sv @@
// One color lane: premultiply, unpremultiply or pass the color through, with a single shared multiplier.
module pac_lane (
  input  pac_pkg::conv_mode_t         mode,
  input  logic [pac_pkg::CHAN_W-1:0]  color,
  input  logic [pac_pkg::CHAN_W-1:0]  alpha,
  input  logic [pac_pkg::RECIP_W-1:0] recip,
  output logic [pac_pkg::CHAN_W-1:0]  result
);
  import pac_pkg::*;

  logic [RECIP_W-1:0] opd;
  logic [PROD_W-1:0]  prod;
  logic [15:0]        prem_x;
  logic [16:0]        prem_q;
  logic [PROD_W:0]    unp_sum;
  logic [16:0]        unp_q;

  // premultiply uses c*a, unpremultiply uses c*recip
  assign opd  = (mode == MODE_PREMUL) ? RECIP_W'(alpha) : recip;
  assign prod = PROD_W'(color) * PROD_W'(opd);

  // (x)/255 for 16-bit x as (x + (x >> 8) + 1) >> 8
  assign prem_x = prod[15:0] + ROUND_PREM;
  assign prem_q = 17'(prem_x) + 17'(prem_x >> 8) + 17'd1;

  assign unp_sum = {1'b0, prod} + ROUND_Q16;
  assign unp_q   = unp_sum[PROD_W:16];

  always_comb begin
    case (mode)
      MODE_PREMUL:   result = prem_q[15:8];
      MODE_UNPREMUL: result = (unp_q > 17'(CHAN_MAX)) ? CHAN_MAX : unp_q[CHAN_W-1:0];
      default:       result = color;
    endcase
  end

endmodule

@@ rtl/core/pixel_alpha_converter_unit.sv @@
// Top level of the pixel alpha converter: input register, three lanes, result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  in_      | sink      | in_valid/in_stall  | red, green, blue, alpha (8b), frame_end
//  out_     | source    | out_valid/out_stall| red, green, blue, alpha (8b), frame_end
//  cfg_     | sink      | cfg_valid/cfg_ready| conversion_mode (2b)
//
// One pixel beat per clock sustained while out_stall is low. The pipeline is the input register
// (which also reads the 256-entry reciprocal table) and the result register,
// with one multiplier per lane in between.
// rst_n is synchronous: both pipeline registers empty, mode = premultiply.
// out_stall holds the result register; the input register keeps taking beats
// until it is full too, then in_stall goes high in the same cycle.
// cfg_ready is always high; the mode register feeds the lanes directly.
module pixel_alpha_converter_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input pixel channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_alpha_in,
  input  logic       in_frame_end_in,
  // result pixel channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_alpha_out,
  output logic       out_frame_end_out,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_conversion_mode
);
  import pac_pkg::*;

  logic [1:0]        mode_r;
  conv_mode_t        mode;

  logic              s1_valid;
  pix_stage_t        s1_pix;
  logic              in_take;
  logic              out_load;

  logic [CHAN_W-1:0] lane_red, lane_green, lane_blue;
  logic [CHAN_W-1:0] red_nxt, blue_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic              frame_end_r;

  // ---- configuration register ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PREMUL;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_conversion_mode;
    end
  end

  // code 3 falls to the pass-through arms below
  assign mode = conv_mode_t'(mode_r);

  // ---- pipeline flow ----
  // result register loads when the input register holds a beat and it is empty or its beat leaves this cycle
  assign out_load = s1_valid && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  pac_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .drain     (out_load),
    .red       (in_red_in),
    .green     (in_green_in),
    .blue      (in_blue_in),
    .alpha     (in_alpha_in),
    .frame_end (in_frame_end_in),
    .valid     (s1_valid),
    .pix       (s1_pix)
  );

  // ---- color lanes ----
  pac_lane u_lane_red (
    .mode   (mode),
    .color  (s1_pix.red),
    .alpha  (s1_pix.alpha),
    .recip  (s1_pix.recip),
    .result (lane_red)
  );

  pac_lane u_lane_green (
    .mode   (mode),
    .color  (s1_pix.green),
    .alpha  (s1_pix.alpha),
    .recip  (s1_pix.recip),
    .result (lane_green)
  );

  pac_lane u_lane_blue (
    .mode   (mode),
    .color  (s1_pix.blue),
    .alpha  (s1_pix.alpha),
    .recip  (s1_pix.recip),
    .result (lane_blue)
  );

  // swap mode exchanges red and blue; lanes pass colors through in that mode
  assign red_nxt  = (mode == MODE_SWAP) ? lane_blue : lane_red;
  assign blue_nxt = (mode == MODE_SWAP) ? lane_red  : lane_blue;

  // ---- result register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r       <= red_nxt;
      green_r     <= lane_green;
      blue_r      <= blue_nxt;
      alpha_r     <= s1_pix.alpha;
      frame_end_r <= s1_pix.frame_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_out       = red_r;
  assign out_green_out     = green_r;
  assign out_blue_out      = blue_r;
  assign out_alpha_out     = alpha_r;
  assign out_frame_end_out = frame_end_r;

endmodule

@@ rtl/core/pac_checker.sv @@
// Port-level checks for the pixel alpha converter, bound to the top level.
module pac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic [7:0] out_alpha_out,
  input logic       out_frame_end_out
);

  // both stages come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // with the result register empty the input register always drains
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // a stalled result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_alpha_out) && $stable(out_frame_end_out))
    else $error("stalled result beat changed");

endmodule

bind pixel_alpha_converter_unit pac_checker u_pac_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_red_out       (out_red_out),
  .out_green_out     (out_green_out),
  .out_blue_out      (out_blue_out),
  .out_alpha_out     (out_alpha_out),
  .out_frame_end_out (out_frame_end_out)
);
